>>> hw/rtl/frls_pkg.sv
// ----------------------------------------------------------------------------
// frls_pkg
// Shared types and constants for the flash record log scan core.
// ----------------------------------------------------------------------------
`default_nettype none

package frls_pkg;

  localparam int unsigned MAX_SLOTS  = 1638;
  localparam int unsigned SLOT_W     = 11;
  localparam int unsigned N_PAY      = 7;
  localparam int unsigned HASH_BYTES = 32;
  localparam int unsigned BYTE_CNT_W = $clog2(HASH_BYTES);

  localparam logic [31:0] SIG_VALID  = 32'h554D_4D32;
  localparam logic [31:0] SIG_ERASED = 32'hFFFF_FFFF;
  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] signature;
    logic [31:0] sequence_req;
    logic [31:0] setpoint;
    logic [31:0] hysteresis;
    logic [31:0] high_limit;
    logic [31:0] low_limit;
    logic [31:0] humidity_zero;
    logic [31:0] humidity_gain;
    logic [31:0] log_period;
    logic [31:0] stored_checksum;
    logic        last_record;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [31:0]       sequence_out;
    logic [31:0]       checksum_out;
    logic [SLOT_W-1:0] free_slot;
    logic [31:0]       setpoint_out;
    logic [31:0]       hysteresis_out;
    logic [31:0]       high_limit_out;
    logic [31:0]       low_limit_out;
    logic [31:0]       humidity_zero_out;
    logic [31:0]       humidity_gain_out;
    logic [31:0]       log_period_out;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_BUILD,
    KIND_ERASED,
    KIND_RECORD
  } kind_t;

  // One classified item, as it travels from front to back.
  typedef struct packed {
    kind_t                  kind;
    logic                   sig_ok;
    logic                   last;
    logic [31:0]            seq;
    logic [N_PAY-1:0][31:0] pay;
    logic [31:0]            checksum;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/frls_front.sv
// ----------------------------------------------------------------------------
// frls_front
// Input stage: takes items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_front import frls_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd
);

  logic hold;
  cmd_t cmd_in;

  always_comb begin
    if (in_item.operation == OP_BUILD) begin
      cmd_in.kind = KIND_BUILD;
    end else if (in_item.signature == SIG_ERASED) begin
      cmd_in.kind = KIND_ERASED;
    end else begin
      cmd_in.kind = KIND_RECORD;
    end
    cmd_in.sig_ok   = (in_item.signature == SIG_VALID);
    cmd_in.last     = in_item.last_record;
    cmd_in.seq      = in_item.sequence_req;
    cmd_in.pay      = {in_item.log_period, in_item.humidity_gain,
                       in_item.humidity_zero, in_item.low_limit,
                       in_item.high_limit, in_item.hysteresis,
                       in_item.setpoint};
    cmd_in.checksum = in_item.stored_checksum;
  end

  assign in_ready  = !hold || cmd_ready;
  assign cmd_valid = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (in_ready) begin
      hold <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/frls_queue.sv
// ----------------------------------------------------------------------------
// frls_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_queue import frls_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/frls_back.sv
// ----------------------------------------------------------------------------
// frls_back
// Execution stage: byte-serial FNV-1a, scan state, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_back import frls_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cmd_valid,
  output logic       cmd_ready,
  input  wire cmd_t  cmd_in,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_DONE
  } state_t;

  state_t                 state;
  cmd_t                   cur;
  logic [31:0]            hash;
  logic [8*HASH_BYTES-1:0] bytes;
  logic [BYTE_CNT_W-1:0]  byte_cnt;

  logic                   have_best;
  logic [31:0]            best_sequence;
  logic [N_PAY-1:0][31:0] best_payload;
  logic [31:0]            next_sequence;
  logic [SLOT_W-1:0]      slot_counter;

  logic [31:0]            hash_next;
  logic [31:0]            seq_diff;
  logic                   newer;
  logic                   take;
  logic [SLOT_W-1:0]      slot_inc;
  logic                   scan_end;
  logic                   emit;
  logic                   can_emit;
  logic                   out_load;
  logic [31:0]            nseq;
  out_item_t              result;

  assign cmd_ready = (state == S_IDLE);

  // One FNV-1a step: xor a byte, multiply by the prime.
  assign hash_next = 32'((hash ^ {24'd0, bytes[7:0]}) * FNV_PRIME);

  assign seq_diff = cur.seq - best_sequence;
  assign newer    = (seq_diff != 32'd0) && !seq_diff[31];
  assign take     = cur.sig_ok && (hash == cur.checksum) && (!have_best || newer);
  assign slot_inc = slot_counter + SLOT_W'(1);
  assign scan_end = cur.last || (slot_inc >= SLOT_W'(MAX_SLOTS));
  assign emit     = (cur.kind != KIND_RECORD) || scan_end;
  assign can_emit = !out_valid || out_ready;
  assign out_load = (state == S_DONE) && emit && can_emit;

  // Winner as seen at the end of a record slot (that slot included).
  always_comb begin
    logic                   win_have;
    logic [31:0]            win_seq;
    logic [N_PAY-1:0][31:0] win_pay;
    win_have = have_best;
    win_seq  = best_sequence;
    win_pay  = best_payload;
    if (cur.kind == KIND_RECORD && take) begin
      win_have = 1'b1;
      win_seq  = cur.seq;
      win_pay  = cur.pay;
    end
    nseq = win_have ? win_seq + 32'd1 : 32'd1;
    result.found        = win_have;
    result.sequence_out = nseq;
    result.checksum_out = 32'd0;
    result.free_slot    = (cur.kind == KIND_ERASED) ? slot_counter : SLOT_W'(MAX_SLOTS);
    if (!win_have) win_pay = '0;
    if (cur.kind == KIND_BUILD) begin
      result.found        = 1'b1;
      result.sequence_out = next_sequence;
      result.checksum_out = hash;
      result.free_slot    = '0;
      win_pay             = cur.pay;
    end
    result.setpoint_out      = win_pay[0];
    result.hysteresis_out    = win_pay[1];
    result.high_limit_out    = win_pay[2];
    result.low_limit_out     = win_pay[3];
    result.humidity_zero_out = win_pay[4];
    result.humidity_gain_out = win_pay[5];
    result.log_period_out    = win_pay[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      have_best     <= 1'b0;
      best_sequence <= '0;
      next_sequence <= 32'd1;
      slot_counter  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= (cmd_in.kind == KIND_ERASED) ? S_DONE : S_HASH;
          end
        end
        S_HASH: begin
          if (byte_cnt == BYTE_CNT_W'(HASH_BYTES - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!emit || can_emit) begin
            state <= S_IDLE;
            if (cur.kind == KIND_BUILD) begin
              next_sequence <= next_sequence + 32'd1;
            end else if (emit) begin
              next_sequence <= nseq;
              have_best     <= 1'b0;
              best_sequence <= '0;
              slot_counter  <= '0;
            end else begin
              slot_counter <= slot_inc;
              if (take) begin
                have_best     <= 1'b1;
                best_sequence <= cur.seq;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur      <= cmd_in;
          hash     <= FNV_BASIS;
          byte_cnt <= '0;
          bytes    <= {cmd_in.pay,
                       (cmd_in.kind == KIND_BUILD) ? next_sequence : cmd_in.seq};
        end
      end
      S_HASH: begin
        hash     <= hash_next;
        bytes    <= {8'd0, bytes[8*HASH_BYTES-1:8]};
        byte_cnt <= byte_cnt + BYTE_CNT_W'(1);
      end
      S_DONE: begin
        if (!emit || can_emit) begin
          if (emit) out_item <= result;
          if (cur.kind == KIND_RECORD && !emit && take) best_payload <= cur.pay;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/flash_record_log_scan_core.sv
// ----------------------------------------------------------------------------
// flash_record_log_scan_core
// Settings record log: scans stored slots for the newest valid record and
// builds new records with their FNV-1a checksum.
// ----------------------------------------------------------------------------
// Back end: a build or non-erased scan item goes through a load step, a
//   byte-serial FNV-1a hash over its 32 sequence and payload bytes, and a
//   commit step; an erased-slot item goes from load straight to commit.
//   The back end takes a new item only once the last one is committed.
//   Path: front register, queue, back end, result register.
// Reset: synchronous, active high; clears the scan state, sets the next
//   sequence to 1 and empties the front register, queue and result register.
`default_nettype none

module flash_record_log_scan_core import frls_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  // Front: registers each item and tags it as build, erased slot or record.
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;

  // Queue to back end.
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  frls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // Two entries let the front keep taking items while the back hashes.
  frls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // Back: hash, newest-record selection, sequence and slot bookkeeping.
  // Mid-region record slots update state only; a result is registered at
  // an erased slot, the last slot, the region bound, or a build.
  frls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_in    (qb_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> verif/tb_flash_record_log_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_record_log_scan_core
// Self-checking bench for the settings record log core. Drives scan and
// build items over the valid/ready input, predicts every result with its
// own model of the scan state and the FNV-1a record hash, and compares each
// returned item field by field. Covers a directed pass (wrap-safe sequence
// ordering, bad checksum and signature, erased and last slots) and a long
// randomized mix with idling on both sides.
// ----------------------------------------------------------------------------

module tb_flash_record_log_scan_core import frls_pkg::*; ();

  // Cycles without any accepted item before the run is declared hung. The
  // slowest legal stretch is a long sender gap plus one hashed item plus a
  // long receiver stall, well under this.
  localparam int QUIET_LIMIT = 2000;
  // Quiet time after the last result, in which any extra result is flagged.
  localparam int TAIL_CYCLES = 120;
  localparam int RANDOM_ITEMS = 1420;

  typedef enum {END_LAST, END_ERASED, END_OPEN} scan_end_t;

  // --------------------------------------------------------------------------
  // Record log predictor and result store.
  // --------------------------------------------------------------------------
  class record_log_scoreboard;
    bit          have_best;
    in_item_t    best_rec;     // winning record; its sequence is the best one
    logic [31:0] next_seq;
    int unsigned slots_seen;
    out_item_t   pending[$];

    int unsigned errors;
    int unsigned checked;
    int unsigned builds;
    int unsigned scans_closed;
    int unsigned scans_found;
    int unsigned region_full;

    function new();
      restart_scan();
      next_seq = 32'd1;
    endfunction

    // FNV-1a over sequence and the seven payload words, low byte first.
    static function logic [31:0] fnv_record(logic [31:0] seq, in_item_t it);
      logic [7:0][31:0] words;
      logic [31:0]      h;
      words = {it.log_period, it.humidity_gain, it.humidity_zero, it.low_limit,
               it.high_limit, it.hysteresis, it.setpoint, seq};
      h = FNV_BASIS;
      for (int w = 0; w < 8; w++) begin
        for (int b = 0; b < 4; b++) begin
          h = h ^ {24'd0, words[w][8*b +: 8]};
          h = h * FNV_PRIME;
        end
      end
      return h;
    endfunction

    function void restart_scan();
      have_best  = 1'b0;
      best_rec   = '0;
      slots_seen = 0;
    endfunction

    function void close_scan(int unsigned free_idx);
      out_item_t r;
      r = '0;
      r.found        = have_best;
      r.sequence_out = have_best ? best_rec.sequence_req + 32'd1 : 32'd1;
      r.free_slot    = SLOT_W'(free_idx);
      if (have_best) begin
        r.setpoint_out      = best_rec.setpoint;
        r.hysteresis_out    = best_rec.hysteresis;
        r.high_limit_out    = best_rec.high_limit;
        r.low_limit_out     = best_rec.low_limit;
        r.humidity_zero_out = best_rec.humidity_zero;
        r.humidity_gain_out = best_rec.humidity_gain;
        r.log_period_out    = best_rec.log_period;
      end
      next_seq = r.sequence_out;
      pending.push_back(r);
      scans_closed++;
      if (have_best) scans_found++;
      if (free_idx == MAX_SLOTS) region_full++;
      restart_scan();
    endfunction

    // Called once per accepted input item, in order.
    function void note_input(in_item_t it);
      out_item_t   r;
      logic [31:0] d;
      if (it.operation == OP_BUILD) begin
        r = '0;
        r.found             = 1'b1;
        r.sequence_out      = next_seq;
        r.checksum_out      = fnv_record(next_seq, it);
        r.setpoint_out      = it.setpoint;
        r.hysteresis_out    = it.hysteresis;
        r.high_limit_out    = it.high_limit;
        r.low_limit_out     = it.low_limit;
        r.humidity_zero_out = it.humidity_zero;
        r.humidity_gain_out = it.humidity_gain;
        r.log_period_out    = it.log_period;
        pending.push_back(r);
        next_seq = next_seq + 32'd1;
        builds++;
      end else if (it.signature == SIG_ERASED) begin
        // erased slot wins over the last mark
        close_scan(slots_seen);
      end else begin
        if (it.signature == SIG_VALID &&
            it.stored_checksum == fnv_record(it.sequence_req, it)) begin
          d = it.sequence_req - best_rec.sequence_req;
          // newer only when strictly ahead by less than half the range
          if (!have_best || (d != 32'd0 && !d[31])) begin
            have_best = 1'b1;
            best_rec  = it;
          end
        end
        slots_seen++;
        if (it.last_record || slots_seen >= MAX_SLOTS) close_scan(MAX_SLOTS);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task match_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, expected %h", checked, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result, sequence_out %h", got.sequence_out));
        return;
      end
      want = pending.pop_front();
      checked++;
      match_field("found", got.found, want.found);
      match_field("sequence_out", got.sequence_out, want.sequence_out);
      match_field("checksum_out", got.checksum_out, want.checksum_out);
      match_field("free_slot", got.free_slot, want.free_slot);
      match_field("setpoint_out", got.setpoint_out, want.setpoint_out);
      match_field("hysteresis_out", got.hysteresis_out, want.hysteresis_out);
      match_field("high_limit_out", got.high_limit_out, want.high_limit_out);
      match_field("low_limit_out", got.low_limit_out, want.low_limit_out);
      match_field("humidity_zero_out", got.humidity_zero_out, want.humidity_zero_out);
      match_field("humidity_gain_out", got.humidity_gain_out, want.humidity_gain_out);
      match_field("log_period_out", got.log_period_out, want.log_period_out);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT.
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  record_log_scoreboard sb = new();

  int unsigned items_sent = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  flash_record_log_scan_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Idle length: mostly none, sometimes a few cycles, rarely a long one.
  function automatic int pick_gap(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Item builders.
  // --------------------------------------------------------------------------
  function automatic in_item_t rand_payload();
    in_item_t it;
    it                 = '0;
    it.operation       = OP_SCAN;
    it.signature       = $urandom;
    it.sequence_req    = $urandom;
    it.setpoint        = $urandom;
    it.hysteresis      = $urandom;
    it.high_limit      = $urandom;
    it.low_limit       = $urandom;
    it.humidity_zero   = $urandom;
    it.humidity_gain   = $urandom;
    it.log_period      = $urandom;
    it.stored_checksum = $urandom;
    return it;
  endfunction

  function automatic in_item_t sealed(in_item_t it);
    it.stored_checksum = record_log_scoreboard::fnv_record(it.sequence_req, it);
    return it;
  endfunction

  // Well-formed stored record: good signature, matching checksum.
  function automatic in_item_t good_record(logic [31:0] seq, bit last);
    in_item_t it;
    it              = rand_payload();
    it.signature    = SIG_VALID;
    it.sequence_req = seq;
    it.last_record  = last;
    return sealed(it);
  endfunction

  function automatic in_item_t with_payload(in_item_t it, logic [31:0] v);
    it.setpoint      = v;
    it.hysteresis    = v;
    it.high_limit    = v;
    it.low_limit     = v;
    it.humidity_zero = v;
    it.humidity_gain = v;
    it.log_period    = v;
    return sealed(it);
  endfunction

  function automatic in_item_t build_item();
    in_item_t it;
    it             = rand_payload();
    it.operation   = OP_BUILD;
    it.last_record = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t erased_item(bit last);
    in_item_t it;
    it             = rand_payload();
    it.signature   = SIG_ERASED;
    it.last_record = last;
    return it;
  endfunction

  // Anything goes: random op, last mark and signature class.
  function automatic in_item_t noise_item();
    in_item_t it;
    it             = rand_payload();
    it.operation   = 1'($urandom_range(0, 1));
    it.last_record = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: it.signature = SIG_ERASED;
      1: begin
        it.signature = SIG_VALID;
        it = sealed(it);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Sequence bases near the interesting spots of the wrap-safe compare.
  function automatic logic [31:0] rand_base();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFF8 + $urandom_range(0, 15);
      2: return 32'h7FFF_FFF8 + $urandom_range(0, 15);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------
  // Present one item and hold it until the block takes it. Handshakes are
  // sampled at the edge, so in_ready is the value from before the edge.
  task automatic send(input in_item_t it);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  // Stop sending and wait for every predicted result. Always waits for a
  // clock edge first so the next valid rise lands in a later step.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // One scan pass: 'slots' stored slots (builds sprinkled in do not count),
  // then the chosen way of ending. END_OPEN leaves the scan running, which
  // with MAX_SLOTS slots hits the region bound.
  task automatic run_scan(int slots, logic [31:0] base, scan_end_t how);
    in_item_t it;
    int       done;
    int       r;
    done = 0;
    while (done < slots) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send(build_item());
      end else begin
        if (r < 60) begin
          it = good_record(base + $urandom_range(0, 16) - 32'd8, 1'b0);
        end else if (r < 72) begin
          it = good_record(base + $urandom_range(0, 16) - 32'd8, 1'b0);
          it.stored_checksum ^= 32'd1 << $urandom_range(0, 31);
        end else if (r < 82) begin
          it = good_record(base + $urandom_range(0, 16) - 32'd8, 1'b0);
          it.signature ^= 32'd1 << $urandom_range(0, 31);
        end else if (r < 92) begin
          it = good_record($urandom, 1'b0);
        end else begin
          it = rand_payload();
        end
        send(it);
        done++;
      end
    end
    case (how)
      END_LAST: begin
        it = good_record(base + $urandom_range(0, 16) - 32'd8, 1'b1);
        if ($urandom_range(0, 3) == 0) it.stored_checksum ^= 32'h0000_0100;
        send(it);
      end
      END_ERASED: send(erased_item(1'($urandom_range(0, 1))));
      default: ;
    endcase
  endtask

  task automatic run_directed();
    in_item_t it;
    // builds with all-zero and all-one payloads, sequence 1 then 2
    it = '0;
    it.operation = OP_BUILD;
    send(it);
    it = '1;
    it.operation = OP_BUILD;
    send(it);
    // empty region: erased first slot, nothing found, free slot 0
    it = '0;
    it.signature = SIG_ERASED;
    send(it);
    // wrap-safe ordering: 0 beats FFFFFFFF, half range and equal do not win
    send(with_payload(good_record(32'hFFFF_FFFF, 1'b0), 32'hFFFF_FFFF));
    send(good_record(32'h0000_0000, 1'b0));
    send(good_record(32'h8000_0000, 1'b0));
    send(good_record(32'h0000_0000, 1'b0));
    // broken checksum, then broken signature with an intact checksum
    it = good_record(32'd5, 1'b0);
    it.stored_checksum ^= 32'h0000_0001;
    send(it);
    it = good_record(32'd6, 1'b0);
    it.signature ^= 32'h8000_0000;
    send(it);
    // build in the middle of a scan leaves the scan alone
    it = '1;
    it.operation = OP_BUILD;
    send(it);
    send(good_record(32'd1, 1'b1));
    // lone record at the top of the range: next sequence wraps to 0
    send(good_record(32'hFFFF_FFFF, 1'b1));
    it = '0;
    it.operation = OP_BUILD;
    send(it);
    // junk slot, then an erased slot that also carries the last mark
    it = '0;
    send(it);
    it = '1;
    it.operation = OP_SCAN;
    send(it);
    // all-zero slot marked last: not valid, region reported full
    it = '0;
    it.last_record = 1'b1;
    send(it);
    // just under half range ahead is still newer
    send(with_payload(good_record(32'h7FFF_FFFF, 1'b0), 32'h0));
    send(with_payload(good_record(32'hFFFF_FFFE, 1'b1), 32'hFFFF_FFFF));
    // a build right after scans, then a sealed all-ones record marked last
    send(build_item());
    it = '1;
    it.operation = OP_SCAN;
    it.signature = SIG_VALID;
    send(sealed(it));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, result checking, hang watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_on) stall_left <= pick_gap(1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int          random_end;
    int          r;
    int          slots;
    scan_end_t   how;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed pass with both sides running flat out
    run_directed();
    drain();

    // randomized mix: mostly well-formed scans, some builds and noise
    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on <= ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        slots = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        how = (r < 45) ? END_LAST : (r < 78) ? END_ERASED : END_OPEN;
        // an open scan always sends something, so each pass spends time
        if (how == END_OPEN && slots == 0) slots = 1;
        run_scan(slots, rand_base(), how);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send(build_item());
      end else begin
        repeat ($urandom_range(1, 6)) send(noise_item());
      end
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));

    $display("sent %0d items: %0d builds, %0d scans closed (%0d found a record, %0d full)",
             items_sent, sb.builds, sb.scans_closed, sb.scans_found, sb.region_full);
    $display("compared %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
